[rtl/eavd_pkg.sv]
// Package for the encoded array value decoder.
// Holds type codes, result kinds, decode phases and the transaction structs.
// No dependencies.
package eavd_pkg;

  // Value header type codes
  localparam logic [4:0] TYPE_BYTE    = 5'h00;
  localparam logic [4:0] TYPE_SHORT   = 5'h02;
  localparam logic [4:0] TYPE_CHAR    = 5'h03;
  localparam logic [4:0] TYPE_INT     = 5'h04;
  localparam logic [4:0] TYPE_NULL    = 5'h1e;
  localparam logic [4:0] TYPE_BOOLEAN = 5'h1f;

  // Last ULEB128 count byte index (fifth byte)
  localparam logic [2:0] CNT_LAST_BYTE = 3'd4;

  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_NULL  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_COUNT   = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_IDLE    = 2'd3
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       start_req;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] position;
    logic [4:0]  vtype;
    kind_e       kind;
    logic [31:0] value;
    logic        last;
  } result_t;

  function automatic logic is_int_type(logic [4:0] t);
    return (t == TYPE_BYTE) || (t == TYPE_SHORT) || (t == TYPE_CHAR) || (t == TYPE_INT);
  endfunction

endpackage

[rtl/eavd_in_stage.sv]
// Input register of the encoded array value decoder.
// Holds one accepted byte until the decode stage takes it. Depends on eavd_pkg.
module eavd_in_stage import eavd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_req_i,
  input  logic       advance_i,
  output item_t      item_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       start_q;
  logic       load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (!valid_q || advance_i) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= data_byte_i;
      start_q <= start_req_i;
    end
  end

  assign item_o = '{valid: valid_q, data_byte: byte_q, start_req: start_q};

endmodule

[rtl/eavd_core.sv]
// Decode stage: count, header and payload phases with all array state.
// Takes one byte per cycle from the input register while the result register can take a result. Depends on eavd_pkg.
module eavd_core import eavd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  logic    advance_i,
  output result_t result_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] count_q, count_d;
  logic [2:0]  cbn_q, cbn_d;
  logic [31:0] pos_q, pos_d;
  logic [4:0]  type_q, type_d;
  logic [3:0]  total_q, total_d;
  logic [3:0]  seen_q, seen_d;
  logic [31:0] acc_q, acc_d;

  logic        fire;
  logic [7:0]  b;
  phase_e      ph_eff;
  logic [31:0] cnt_eff;
  logic [2:0]  cbn_eff;
  logic [31:0] cnt_new;
  logic        cnt_done;
  logic [31:0] acc_new;
  logic [3:0]  seen_new;
  logic        pay_done;
  logic        fin;
  logic [4:0]  hdr_type;
  logic [2:0]  hdr_arg;
  logic [31:0] int_val;

  assign fire = item_i.valid && advance_i;
  assign b    = item_i.data_byte;

  // start_req behaves as a reset of the decode state on this byte
  assign ph_eff  = item_i.start_req ? PH_COUNT : phase_q;
  assign cnt_eff = item_i.start_req ? '0 : count_q;
  assign cbn_eff = item_i.start_req ? '0 : cbn_q;

  assign hdr_type = b[4:0];
  assign hdr_arg  = b[7:5];
  assign fin      = ((pos_q + 32'd1) == count_q);

  always_comb begin
    cnt_new  = cnt_eff;
    cnt_done = 1'b1;
    case (cbn_eff)
      3'd0: begin
        cnt_new  = cnt_eff | {25'd0, b[6:0]};
        cnt_done = !b[7];
      end
      3'd1: begin
        cnt_new  = cnt_eff | {18'd0, b[6:0], 7'd0};
        cnt_done = !b[7];
      end
      3'd2: begin
        cnt_new  = cnt_eff | {11'd0, b[6:0], 14'd0};
        cnt_done = !b[7];
      end
      3'd3: begin
        cnt_new  = cnt_eff | {4'd0, b[6:0], 21'd0};
        cnt_done = !b[7];
      end
      default: begin
        // fifth byte lands unmasked at bit 28; upper bits fall off
        cnt_new  = cnt_eff | {b[3:0], 28'd0};
        cnt_done = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (seen_q)
      4'd0:    acc_new = acc_q | {24'd0, b};
      4'd1:    acc_new = acc_q | {16'd0, b, 8'd0};
      4'd2:    acc_new = acc_q | {8'd0, b, 16'd0};
      4'd3:    acc_new = acc_q | {b, 24'd0};
      default: acc_new = acc_q;
    endcase
  end

  assign seen_new = seen_q + 4'd1;
  assign pay_done = !(seen_new < total_q);

  always_comb begin
    case (total_q)
      4'd1:    int_val = {{24{acc_new[7]}}, acc_new[7:0]};
      4'd2:    int_val = {{16{acc_new[15]}}, acc_new[15:0]};
      4'd3:    int_val = {{8{acc_new[23]}}, acc_new[23:0]};
      default: int_val = acc_new;
    endcase
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    cbn_d   = cbn_q;
    pos_d   = pos_q;
    type_d  = type_q;
    total_d = total_q;
    seen_d  = seen_q;
    acc_d   = acc_q;
    if (fire) begin
      if (item_i.start_req) begin
        phase_d = PH_COUNT;
        count_d = '0;
        cbn_d   = '0;
        pos_d   = '0;
      end
      unique case (ph_eff)
        PH_COUNT: begin
          count_d = cnt_new;
          cbn_d   = cbn_eff + 3'd1;
          if (cnt_done) begin
            pos_d   = '0;
            phase_d = (cnt_new == '0) ? PH_IDLE : PH_HEADER;
          end else begin
            phase_d = PH_COUNT;
          end
        end
        PH_HEADER: begin
          type_d = hdr_type;
          if (hdr_type == TYPE_BOOLEAN || hdr_type == TYPE_NULL) begin
            pos_d   = pos_q + 32'd1;
            phase_d = fin ? PH_IDLE : PH_HEADER;
          end else begin
            total_d = {1'b0, hdr_arg} + 4'd1;
            seen_d  = '0;
            acc_d   = '0;
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          acc_d  = acc_new;
          seen_d = seen_new;
          if (pay_done) begin
            pos_d   = pos_q + 32'd1;
            phase_d = fin ? PH_IDLE : PH_HEADER;
          end
        end
        PH_IDLE: begin
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Result
  always_comb begin
    result_o = '{valid: 1'b0, position: pos_q, vtype: hdr_type, kind: KIND_NULL,
                 value: '0, last: fin};
    if (fire) begin
      unique case (ph_eff)
        PH_COUNT: begin
          if (cnt_done && cnt_new == '0) begin
            result_o.valid    = 1'b1;
            result_o.position = '0;
            result_o.vtype    = '0;
            result_o.kind     = KIND_EMPTY;
            result_o.last     = 1'b1;
          end
        end
        PH_HEADER: begin
          if (hdr_type == TYPE_BOOLEAN) begin
            result_o.valid = 1'b1;
            result_o.kind  = KIND_INT;
            result_o.value = {29'd0, hdr_arg};
          end else if (hdr_type == TYPE_NULL) begin
            result_o.valid = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          result_o.vtype = type_q;
          if (pay_done) begin
            result_o.valid = 1'b1;
            if (is_int_type(type_q)) begin
              result_o.kind  = KIND_INT;
              result_o.value = int_val;
            end
          end
        end
        PH_IDLE: begin
          result_o.valid = 1'b0;
        end
        default: begin
          result_o.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      count_q <= '0;
      cbn_q   <= '0;
      pos_q   <= '0;
      type_q  <= '0;
      total_q <= '0;
      seen_q  <= '0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      cbn_q   <= cbn_d;
      pos_q   <= pos_d;
      type_q  <= type_d;
      total_q <= total_d;
      seen_q  <= seen_d;
      acc_q   <= acc_d;
    end
  end

endmodule

[rtl/eavd_out_stage.sv]
// Result register of the encoded array value decoder.
// Holds one result transaction while the receiver stalls. Depends on eavd_pkg.
module eavd_out_stage import eavd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  result_t            result_i,
  input  logic               out_stall_i,
  output logic               advance_o,
  output logic               out_valid_o,
  output logic [31:0]        position_o,
  output logic [4:0]         value_type_o,
  output logic [1:0]         kind_o,
  output logic signed [31:0] value_o,
  output logic               last_o
);

  logic        valid_q, valid_d;
  logic [31:0] pos_q;
  logic [4:0]  type_q;
  kind_e       kind_q;
  logic [31:0] value_q;
  logic        last_q;

  // register may take a new result when empty or being drained
  assign advance_o = !(valid_q && out_stall_i);

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = result_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && result_i.valid) begin
      pos_q   <= result_i.position;
      type_q  <= result_i.vtype;
      kind_q  <= result_i.kind;
      value_q <= result_i.value;
      last_q  <= result_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign position_o   = pos_q;
  assign value_type_o = type_q;
  assign kind_o       = kind_q;
  assign value_o      = signed'(value_q);
  assign last_o       = last_q;

endmodule

[rtl/encoded_array_value_decoder.sv]
// Encoded array value decoder, top level.
//
// Input channel: one byte of an encoded array per transaction (data_byte_i),
// with start_req_i marking the first count byte of a new array. A ULEB128
// element count (up to five bytes) is followed by that many values, each a
// header byte plus its payload bytes.
// Output channel: one transaction per decoded value, carrying its position,
// type code, kind (integer, null/skipped, empty marker), sign-extended value
// and a last flag. A zero count produces a single empty marker.
// Both channels use valid/stall; a transaction completes when valid is high
// and stall is low.
// Throughput: one byte per cycle while the receiver does not stall. The byte
// completing a value sits in the input register, then decodes into the
// result register, where its result becomes visible.
// Stall: while the receiver stalls a held result, the byte in the input
// register waits and in_stall_o rises; the pipeline drains without loss.
// Reset: the valid flags and decode state clear, and the block expects a count byte first.
// Bytes after the array's last value are dropped until start_req_i is set.
module encoded_array_value_decoder import eavd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               start_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        position_o,
  output logic [4:0]         value_type_o,
  output logic [1:0]         kind_o,
  output logic signed [31:0] value_o,
  output logic               last_o
);

  item_t   item;
  result_t result;
  logic    advance;

  eavd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .start_req_i (start_req_i),
    .advance_i   (advance),
    .item_o      (item)
  );

  eavd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .advance_i (advance),
    .result_o  (result)
  );

  eavd_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .result_i     (result),
    .out_stall_i  (out_stall_i),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .position_o   (position_o),
    .value_type_o (value_type_o),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .last_o       (last_o)
  );

endmodule

[rtl/eavd_checker.sv]
// Port-level checks for the encoded array value decoder.
// Bound to the top level; depends on eavd_pkg.
module eavd_checker import eavd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [31:0]        position_o,
  input logic [4:0]         value_type_o,
  input logic [1:0]         kind_o,
  input logic signed [31:0] value_o,
  input logic               last_o
);

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_EMPTY) |->
      (last_o && position_o == '0 && value_o == '0 && value_type_o == '0))
    else $error("malformed empty marker");

  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_INT) |-> (value_o == '0))
    else $error("non-integer result with nonzero value");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(position_o) && $stable(value_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind encoded_array_value_decoder eavd_checker u_eavd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .position_o   (position_o),
  .value_type_o (value_type_o),
  .kind_o       (kind_o),
  .value_o      (value_o),
  .last_o       (last_o)
);

[sim/encoded_array_value_decoder_tb.sv]
// Testbench for encoded_array_value_decoder: drives encoded array byte streams and checks
// every decoded value against a cycle-free decoder model kept in this file.
// Depends on rtl/eavd_pkg.sv and rtl/encoded_array_value_decoder.sv.
module encoded_array_value_decoder_tb;
  import eavd_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        data_byte_i = 8'h00;
  logic              start_req_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [31:0]       position_o;
  logic [4:0]        value_type_o;
  logic [1:0]        kind_o;
  logic signed [31:0] value_o;
  logic              last_o;

  encoded_array_value_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .start_req_i  (start_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .position_o   (position_o),
    .value_type_o (value_type_o),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .last_o       (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  typedef struct {
    logic [31:0] position;
    logic [4:0]  vtype;
    kind_e       kind;
    logic [31:0] value;
    logic        last;
  } decoded_value_t;

  decoded_value_t pending_values[$];

  // decoder model state
  phase_e      dec_phase;
  logic [31:0] cnt_val;
  logic [2:0]  cnt_bytes;
  logic [31:0] val_pos;
  logic [4:0]  cur_type;
  logic [3:0]  pay_total;
  logic [3:0]  pay_seen;
  logic [31:0] acc;

  int errors = 0;
  int bytes_sent = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  function automatic void restart_decoder();
    dec_phase = PH_COUNT;
    cnt_val   = '0;
    cnt_bytes = '0;
    val_pos   = '0;
    cur_type  = '0;
    pay_total = '0;
    pay_seen  = '0;
    acc       = '0;
  endfunction

  function automatic void emit_value(kind_e k, logic [31:0] v);
    decoded_value_t d;
    logic fin;
    fin = (val_pos + 32'd1) == cnt_val;
    d.position = val_pos;
    d.vtype    = cur_type;
    d.kind     = k;
    d.value    = (k == KIND_INT) ? v : 32'd0;
    d.last     = fin;
    pending_values = {pending_values, d};
    val_pos   = val_pos + 32'd1;
    dec_phase = fin ? PH_IDLE : PH_HEADER;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic s);
    decoded_value_t d;
    logic done;
    int bits;
    if (s) restart_decoder();
    case (dec_phase)
      PH_COUNT: begin
        if (cnt_bytes < CNT_LAST_BYTE) begin
          cnt_val = cnt_val | ({25'd0, b[6:0]} << (7 * cnt_bytes));
          done = !b[7];
        end else begin
          // fifth byte goes in whole; bits past 31 drop
          cnt_val = cnt_val | {b[3:0], 28'd0};
          done = 1'b1;
        end
        cnt_bytes = cnt_bytes + 3'd1;
        if (done) begin
          val_pos = '0;
          if (cnt_val == 32'd0) begin
            dec_phase  = PH_IDLE;
            d.position = '0;
            d.vtype    = '0;
            d.kind     = KIND_EMPTY;
            d.value    = '0;
            d.last     = 1'b1;
            pending_values = {pending_values, d};
          end else begin
            dec_phase = PH_HEADER;
          end
        end
      end
      PH_HEADER: begin
        cur_type = b[4:0];
        if (cur_type == TYPE_BOOLEAN) begin
          emit_value(KIND_INT, {29'd0, b[7:5]});
        end else if (cur_type == TYPE_NULL) begin
          emit_value(KIND_NULL, 32'd0);
        end else begin
          pay_total = {1'b0, b[7:5]} + 4'd1;
          pay_seen  = '0;
          acc       = '0;
          dec_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (pay_seen < 4'd4) acc = acc | ({24'd0, b} << (8 * pay_seen));
        pay_seen = pay_seen + 4'd1;
        if (pay_seen >= pay_total) begin
          if (cur_type == TYPE_BYTE || cur_type == TYPE_SHORT ||
              cur_type == TYPE_CHAR || cur_type == TYPE_INT) begin
            if (pay_total < 4'd4) begin
              bits = 8 * pay_total;
              if (acc[bits-1]) acc = acc | (32'hffff_ffff << bits);
            end
            emit_value(KIND_INT, acc);
          end else begin
            emit_value(KIND_NULL, 32'd0);
          end
        end
      end
      default: ;  // idle: bytes dropped until a start
    endcase
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, field, got, want);
    errors++;
  endtask

  // result side: random stall per transaction, compare against oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    decoded_value_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_values.size() == 0) begin
          flag_mismatch("unexpected result, position", position_o, 32'd0);
        end else begin
          e = pending_values.pop_front();
          if (position_o !== e.position) flag_mismatch("position", position_o, e.position);
          if (value_type_o !== e.vtype)
            flag_mismatch("value_type", 32'(value_type_o), 32'(e.vtype));
          if (kind_o !== e.kind) flag_mismatch("kind", 32'(kind_o), 32'(e.kind));
          if (value_o !== e.value) flag_mismatch("value", value_o, e.value);
          if (last_o !== e.last) flag_mismatch("last", 32'(last_o), 32'(e.last));
        end
        stall_left = calm ? 0 : $urandom_range(0, 9);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic s);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    start_req_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    decode_byte(b, s);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_empty_and_idle();
    push_byte(8'h00, 1'b0);  // counted without a start right after reset
    push_byte(8'h55, 1'b0);  // after the array: dropped
  endtask

  task automatic test_value_types();
    push_byte(8'h05, 1'b1);
    push_byte(8'hff, 1'b0);  // boolean, arg 7
    push_byte(8'hfe, 1'b0);  // null, arg bits ignored
    push_byte(8'h00, 1'b0);  // byte, one payload byte
    push_byte(8'h80, 1'b0);
    push_byte(8'h3c, 1'b0);  // array type: two bytes skipped
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'ha4, 1'b0);  // int with six bytes, last two dropped
    push_byte(8'h78, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h92, 1'b0);
    push_byte(8'haa, 1'b0);
    push_byte(8'hbb, 1'b0);
  endtask

  task automatic test_long_count_and_restart();
    push_byte(8'hff, 1'b1);  // five-byte count, all ones
    repeat (4) push_byte(8'hff, 1'b0);
    push_byte(8'h22, 1'b0);  // short, negative
    push_byte(8'hff, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b1);  // abandon the huge array
    push_byte(8'h23, 1'b0);  // char, two bytes
    push_byte(8'h01, 1'b0);
    push_byte(8'h83, 1'b0);
  endtask

  task automatic test_random_arrays();
    logic [7:0] stream[$];
    logic [4:0] vt;
    int n, cut, pad, arg, r;
    while (bytes_sent < 1620) begin
      calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      stream.delete();
      if (r < 90) begin
        case ($urandom_range(0, 9))
          0: n = 0;
          1: n = $urandom_range(7, 20);
          default: n = $urandom_range(1, 6);
        endcase
        pad = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        if (pad == 0) begin
          stream = {stream, 8'(n)};
        end else begin
          stream = {stream, 8'(n) | 8'h80};
          repeat (pad - 1) stream = {stream, 8'h80};
          stream = {stream, 8'h00};
        end
        // a broken array stops early; the next start abandons it
        cut = (r >= 80 && n > 0) ? $urandom_range(0, n - 1) : n;
        repeat (cut) begin
          arg = $urandom_range(0, 7);
          case ($urandom_range(0, 9))
            0: vt = TYPE_BYTE;
            1: vt = TYPE_SHORT;
            2: vt = TYPE_CHAR;
            3, 4: vt = TYPE_INT;
            5: vt = TYPE_BOOLEAN;
            6: vt = TYPE_NULL;
            default: vt = 5'($urandom_range(0, 31));
          endcase
          if (vt <= TYPE_INT && $urandom_range(0, 2) != 0) arg = $urandom_range(0, 3);
          stream = {stream, {3'(arg), vt}};
          if (vt != TYPE_BOOLEAN && vt != TYPE_NULL)
            repeat (arg + 1) stream = {stream, pick_byte()};
        end
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) stream = {stream, 8'($urandom_range(0, 255))};
        foreach (stream[i]) push_byte(stream[i], i == 0);
      end else begin
        repeat ($urandom_range(1, 8))
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    restart_decoder();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_idle();
    test_value_types();
    test_long_count_and_restart();
    test_random_arrays();
    in_valid_i <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/eavd_pkg.sv
rtl/eavd_in_stage.sv
rtl/eavd_core.sv
rtl/eavd_out_stage.sv
rtl/encoded_array_value_decoder.sv
rtl/eavd_checker.sv
sim/encoded_array_value_decoder_tb.sv
